/* rtl/core/utf8_to_code_point_decoder_defines.svh */
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_defines.svh
// Assertion macros used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

// Checked on every edge outside reset.
`define U8D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every edge, reset included.
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/core/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and helpers shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned PEND_W = 2;

    typedef enum logic [1:0] {
        STAT_CHAR     = 2'd0,
        STAT_BAD_LEAD = 2'd1,
        STAT_BAD_CONT = 2'd2
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0]   partial;
        logic [PEND_W-1:0] pending;
        logic              discarding;
    } dec_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        status_t         status;
    } dec_result_t;

    // Low two bytes swapped for a big-endian target; bits 20..16 kept.
    function automatic logic [CP_W-1:0] finish_cp(input logic [CP_W-1:0] cp,
                                                  input logic            swap);
        logic [CP_W-1:0] res;
        res = cp;
        if (swap) begin
            res = {cp[20:16], cp[7:0], cp[15:8]};
        end
        return res;
    endfunction

endpackage

/* rtl/core/utf8_to_code_point_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Streaming UTF-8 decoder: one byte in, at most one code point out.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte per transfer, s_in_last marks a string's end.
// Result channel m_*: a code point with status (0 character, 1 bad lead,
// 2 missing or bad continuation) and m_out_last copied from the byte that
// produced it. Bytes mid-sequence, and bytes dropped after an error, give
// no result.
// Throughput: one byte per cycle while the receiver takes results. The
// decode step sits between the input handshake and a single output
// register, so a result appears in the cycle after the transfer of its byte.
// If the receiver stalls, s_ready stays high as long as the output register
// is empty or is being taken in the same cycle; otherwise it drops.
// cfg_wr_en / cfg_wr_data set swap_low_bytes (swap bits 15..8 and 7..0).
// Reset (aresetn low, synchronous) clears the sequence state, the discard
// flag, the output valid flag and swap_low_bytes.
// ----------------------------------------------------------------------------
`include "utf8_to_code_point_decoder_defines.svh"

module utf8_to_code_point_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    input  logic                      s_in_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [u8d_pkg::CP_W-1:0]  m_code_point,
    output logic [1:0]                m_status,
    output logic                      m_out_last
);
    import u8d_pkg::*;

    logic            swap_reg;
    dec_state_t      state_reg, state_next, step_state;
    dec_result_t     step_res;
    logic            m_valid_reg;
    logic [CP_W-1:0] cp_reg;
    status_t         status_reg;
    logic            last_reg;
    logic            in_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    u8d_step u_step (
        .in_byte  (s_in_byte),
        .in_last  (s_in_last),
        .swap     (swap_reg),
        .state_i  (state_reg),
        .state_o  (step_state),
        .result_o (step_res)
    );

    assign state_next = in_xfer ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg    <= 1'b0;
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                swap_reg <= cfg_wr_data;
            end
            state_reg <= state_next;
            if (in_xfer) begin
                m_valid_reg <= step_res.emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && step_res.emit) begin
            cp_reg     <= step_res.code_point;
            status_reg <= step_res.status;
            last_reg   <= s_in_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = status_reg;
    assign m_out_last   = last_reg;

    `U8D_ASSERT(a_last_clears, (in_xfer && s_in_last) |=> (state_reg == '0), "state left after last")
    `U8D_ASSERT(a_err_zero_cp, m_valid_reg && status_reg != STAT_CHAR |-> cp_reg == '0, "error cp nonzero")
    `U8D_ASSERT(a_discard_idle, state_reg.discarding |-> state_reg == dec_state_t'(1), "discard mid-sequence")
    `U8D_ASSERT(a_discard_silent, (in_xfer && state_reg.discarding) |=> !m_valid_reg, "result while discarding")
    `U8D_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid_reg && state_reg == '0), "not cleared by reset")

endmodule

/* rtl/core/u8d_step.sv */
// ----------------------------------------------------------------------------
// u8d_step
// Next-state and result logic for one byte of the UTF-8 decoder.
// ----------------------------------------------------------------------------
module u8d_step (
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 swap,
    input  u8d_pkg::dec_state_t  state_i,
    output u8d_pkg::dec_state_t  state_o,
    output u8d_pkg::dec_result_t result_o
);
    import u8d_pkg::*;

    logic [CP_W-1:0]   shifted;
    logic [PEND_W-1:0] pend_dec;

    assign shifted  = {state_i.partial[CP_W-7:0], in_byte[5:0]};
    assign pend_dec = state_i.pending - PEND_W'(1);

    always_comb begin
        state_o             = state_i;
        result_o.emit       = 1'b0;
        result_o.code_point = '0;
        result_o.status     = STAT_CHAR;

        if (state_i.discarding) begin
            state_o.discarding = !in_last;
        end else if (state_i.pending != '0) begin
            if (in_byte[7:6] != 2'b10) begin
                state_o         = '{partial: '0, pending: '0, discarding: !in_last};
                result_o.emit   = 1'b1;
                result_o.status = STAT_BAD_CONT;
            end else if (pend_dec == '0) begin
                state_o             = '0;
                result_o.emit       = 1'b1;
                result_o.code_point = finish_cp(shifted, swap);
            end else if (in_last) begin
                // string ended with continuations still due
                state_o         = '0;
                result_o.emit   = 1'b1;
                result_o.status = STAT_BAD_CONT;
            end else begin
                state_o.partial = shifted;
                state_o.pending = pend_dec;
            end
        end else begin
            case (in_byte) inside
                8'b0???????: begin
                    result_o.emit       = 1'b1;
                    result_o.code_point = finish_cp({13'd0, in_byte}, swap);
                end
                8'b10??????, 8'b11111???: begin
                    state_o.discarding = !in_last;
                    result_o.emit      = 1'b1;
                    result_o.status    = STAT_BAD_LEAD;
                end
                8'b110?????: begin
                    state_o.partial = {16'd0, in_byte[4:0]};
                    state_o.pending = PEND_W'(1);
                end
                8'b1110????: begin
                    state_o.partial = {17'd0, in_byte[3:0]};
                    state_o.pending = PEND_W'(2);
                end
                default: begin
                    state_o.partial = {18'd0, in_byte[2:0]};
                    state_o.pending = PEND_W'(3);
                end
            endcase
            if (in_last && !result_o.emit) begin
                // lone lead as the final byte
                state_o         = '0;
                result_o.emit   = 1'b1;
                result_o.status = STAT_BAD_CONT;
            end
        end
    end

endmodule
